// ----- sv/two_circular_task_queues_defines.svh -----
// assertion macros for the two circular task queues
`ifndef TWO_CIRCULAR_TASK_QUEUES_DEFINES_SVH
`define TWO_CIRCULAR_TASK_QUEUES_DEFINES_SVH

// same-cycle implication
`define TCQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tcq_pkg.sv -----
// package with types and constants of the two circular task queues
`default_nettype none

package tcq_pkg;

  localparam int unsigned TaskIdW     = 6;
  localparam int unsigned IdSpace     = 1 << TaskIdW;
  localparam int unsigned MaxTasksDef = 64;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_ROTATE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_QUEUED    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_ROTATE = 2'd3
  } chain_op_e;

  typedef struct packed {
    chain_op_e          op;
    logic [TaskIdW-1:0] id;
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/tcq_ifs.sv -----
// request and result channel interfaces
`default_nettype none

interface tcq_req_if;
  import tcq_pkg::*;
  logic               valid;
  logic               ready;
  action_e            action;
  logic               queue_select;
  logic [TaskIdW-1:0] task_id;
  modport source (output valid, action, queue_select, task_id, input ready);
  modport sink (input valid, action, queue_select, task_id, output ready);
endinterface

interface tcq_rsp_if;
  import tcq_pkg::*;
  logic               valid;
  logic               ready;
  status_e            result_status;
  logic [TaskIdW-1:0] result_id;
  modport source (output valid, result_status, result_id, input ready);
  modport sink (input valid, result_status, result_id, output ready);
endinterface

`default_nettype wire

// ----- sv/two_circular_task_queues.sv -----
// top level of the two circular task queues
//
//   channel  dir  fields                              handshake
//   req_i    in   action, queue_select, task_id       valid/ready
//   rsp_o    out  result_status, result_id            valid/ready
//
// push, pop, rotate: S_CHECK, then S_RESULT loads the output register
// remove: S_CHECK, then one S_WALK step per entry, the chain rotating one slot a cycle
// one request in flight; the next is taken while a result waits in the output register
// a stalled result holds the request side once the next one is done
// reset clears both chains, counts and membership at once
`default_nettype none

module two_circular_task_queues #(
  parameter int unsigned MAX_TASKS = tcq_pkg::MaxTasksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcq_req_if.sink    req_i,
  tcq_rsp_if.source  rsp_o
);
  import tcq_pkg::*;

  localparam int unsigned NumEntries = (MAX_TASKS < IdSpace) ? MAX_TASKS : IdSpace;
  localparam int unsigned IdxW       = $clog2(NumEntries);
  localparam int unsigned CntW       = $clog2(NumEntries + 1);
  localparam int unsigned IdExtW     = TaskIdW + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_WALK   = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  action_e            act_q;
  logic               sel_q;
  logic [TaskIdW-1:0] id_q;
  logic               queued_q, queued_in;
  logic [CntW-1:0]    run_cnt_q, run_cnt_d, dead_cnt_q, dead_cnt_d;
  logic [CntW-1:0]    steps_q, steps_d;
  logic               found_q, found_d;
  status_e            res_status_q, res_status_d;
  logic [TaskIdW-1:0] res_id_q, res_id_d;
  logic [NumEntries-1:0] member_q, member_d;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [TaskIdW-1:0] out_id_q;

  logic               req_acc, out_load, in_range, tgt_dead, hit;
  logic [CntW-1:0]    cur_cnt, cur_cnt_nxt;
  logic               cnt_inc, cnt_dec;
  logic               mem_set, mem_clr;
  logic [IdxW-1:0]    mem_idx;
  chain_op_e          op_sel;
  logic [TaskIdW-1:0] run_head, dead_head, cur_head;
  chain_ctrl_t        run_ctrl, dead_ctrl;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_RESULT) && (!out_valid_q || rsp_o.ready);

  assign in_range = ({1'b0, id_q} < IdExtW'(NumEntries));
  assign tgt_dead = sel_q && (act_q != ACT_ROTATE);
  assign cur_cnt  = tgt_dead ? dead_cnt_q : run_cnt_q;
  assign cur_head = tgt_dead ? dead_head : run_head;
  assign hit      = !found_q && (cur_head == id_q);

  always_comb begin
    queued_in = 1'b0;
    for (int i = 0; i < NumEntries; i++) begin
      if (req_i.task_id == TaskIdW'(i)) begin
        queued_in = member_q[i];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    steps_d      = steps_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    op_sel       = OP_HOLD;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    mem_set      = 1'b0;
    mem_clr      = 1'b0;
    mem_idx      = id_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d      = S_RESULT;
        res_status_d = ST_OK;
        res_id_d     = '0;
        unique case (act_q)
          ACT_PUSH: begin
            if (!in_range) begin
              res_status_d = ST_NOT_FOUND;
            end else if (queued_q) begin
              res_status_d = ST_QUEUED;
            end else begin
              op_sel   = OP_PUSH;
              cnt_inc  = 1'b1;
              mem_set  = 1'b1;
              res_id_d = id_q;
            end
          end
          ACT_POP: begin
            if (cur_cnt == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              op_sel   = OP_POP;
              cnt_dec  = 1'b1;
              mem_clr  = 1'b1;
              mem_idx  = cur_head[IdxW-1:0];
              res_id_d = cur_head;
            end
          end
          ACT_REMOVE: begin
            if (cur_cnt == '0) begin
              res_status_d = ST_EMPTY;
            end else if (!in_range) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              steps_d = cur_cnt;
              found_d = 1'b0;
              state_d = S_WALK;
            end
          end
          ACT_ROTATE: begin
            if (cur_cnt == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              op_sel   = OP_ROTATE;
              res_id_d = cur_head;
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        // drop the match, rotate past everything else
        if (hit) begin
          op_sel  = OP_POP;
          cnt_dec = 1'b1;
          mem_clr = 1'b1;
          found_d = 1'b1;
        end else begin
          op_sel = OP_ROTATE;
        end
        steps_d = steps_q - CntW'(1);
        if (steps_q == CntW'(1)) begin
          state_d = S_RESULT;
          if (found_q || hit) begin
            res_status_d = ST_OK;
            res_id_d     = id_q;
          end else begin
            res_status_d = ST_NOT_FOUND;
            res_id_d     = '0;
          end
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cur_cnt_nxt = cur_cnt;
    if (cnt_inc) begin
      cur_cnt_nxt = cur_cnt + CntW'(1);
    end else if (cnt_dec) begin
      cur_cnt_nxt = cur_cnt - CntW'(1);
    end
    run_cnt_d  = tgt_dead ? run_cnt_q : cur_cnt_nxt;
    dead_cnt_d = tgt_dead ? cur_cnt_nxt : dead_cnt_q;

    member_d = member_q;
    if (mem_set) begin
      member_d[mem_idx] = 1'b1;
    end else if (mem_clr) begin
      member_d[mem_idx] = 1'b0;
    end

    run_ctrl.op  = tgt_dead ? OP_HOLD : op_sel;
    run_ctrl.id  = id_q;
    dead_ctrl.op = tgt_dead ? op_sel : OP_HOLD;
    dead_ctrl.id = id_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_cnt_q   <= '0;
      dead_cnt_q  <= '0;
      member_q    <= '0;
      steps_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_cnt_q  <= run_cnt_d;
      dead_cnt_q <= dead_cnt_d;
      member_q   <= member_d;
      steps_q    <= steps_d;
      found_q    <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      act_q    <= req_i.action;
      sel_q    <= req_i.queue_select;
      id_q     <= req_i.task_id;
      queued_q <= queued_in;
    end
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
    end
  end

  tcq_chain #(
    .DEPTH (NumEntries)
  ) u_run_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (run_ctrl),
    .head_id_o (run_head)
  );

  tcq_chain #(
    .DEPTH (NumEntries)
  ) u_dead_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (dead_ctrl),
    .head_id_o (dead_head)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_status = out_status_q;
  assign rsp_o.result_id     = out_id_q;

endmodule

`default_nettype wire

// ----- sv/tcq_cell.sv -----
// one slot of a queue chain, shifts toward the head
`default_nettype none

module tcq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcq_pkg::chain_ctrl_t          ctrl_i,
  input  logic [tcq_pkg::TaskIdW-1:0]   head_id_i,
  input  logic                          left_valid_i,
  input  logic                          right_valid_i,
  input  logic [tcq_pkg::TaskIdW-1:0]   right_id_i,
  output logic                          valid_o,
  output logic [tcq_pkg::TaskIdW-1:0]   id_o
);
  import tcq_pkg::*;

  logic               valid_q, valid_d;
  logic [TaskIdW-1:0] id_q, id_d;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    case (ctrl_i.op)
      OP_PUSH: begin
        if (!valid_q && left_valid_i) begin
          valid_d = 1'b1;
          id_d    = ctrl_i.id;
        end
      end
      OP_POP: begin
        valid_d = right_valid_i;
        id_d    = right_id_i;
      end
      OP_ROTATE: begin
        // the tail slot takes the old head
        if (valid_q && !right_valid_i) begin
          id_d = head_id_i;
        end else begin
          valid_d = right_valid_i;
          id_d    = right_id_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;

endmodule

`default_nettype wire

// ----- sv/tcq_chain.sv -----
// row of slots holding one queue in order, head in slot zero
`default_nettype none

module tcq_chain #(
  parameter int unsigned DEPTH = tcq_pkg::MaxTasksDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcq_pkg::chain_ctrl_t        ctrl_i,
  output logic [tcq_pkg::TaskIdW-1:0] head_id_o
);
  import tcq_pkg::*;

  logic [DEPTH+1:0]   vpad;
  logic [TaskIdW-1:0] idpad [DEPTH+1];

  assign vpad[0]         = 1'b1;
  assign vpad[DEPTH+1]   = 1'b0;
  assign idpad[DEPTH]    = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tcq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .head_id_i     (idpad[0]),
      .left_valid_i  (vpad[i]),
      .right_valid_i (vpad[i+2]),
      .right_id_i    (idpad[i+1]),
      .valid_o       (vpad[i+1]),
      .id_o          (idpad[i])
    );
  end

  assign head_id_o = idpad[0];

endmodule

`default_nettype wire

// ----- sv/tcq_checker.sv -----
// port checker for the two circular task queues and its bind
`default_nettype none

`include "two_circular_task_queues_defines.svh"

module tcq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input tcq_pkg::status_e            rsp_status_i,
  input logic [tcq_pkg::TaskIdW-1:0] rsp_id_i
);
  import tcq_pkg::*;

  `TCQ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_id_i), "result changed while stalled")
  `TCQ_ASSERT_IMPLY(a_err_id_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != ST_OK), rsp_id_i == '0, "nonzero id with error status")
  `TCQ_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while one is in flight")

endmodule

bind two_circular_task_queues tcq_checker u_tcq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.result_status),
  .rsp_id_i     (rsp_o.result_id)
);

`default_nettype wire
